// ===== hw/rtl/bgc_pkg.sv =====
package bgc_pkg;

	// Register width of every configuration threshold
	localparam int unsigned REG_W = 12;
	localparam int unsigned CFG_IDX_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_GAP = 3'd4;

	// Reset values of the thresholds
	localparam logic [REG_W-1:0] RST_SETTLE     = 12'd10;
	localparam logic [REG_W-1:0] RST_DEBOUNCE   = 12'd10;
	localparam logic [REG_W-1:0] RST_LONG_PRESS = 12'd2500;
	localparam logic [REG_W-1:0] RST_RELEASE    = 12'd30;
	localparam logic [REG_W-1:0] RST_DOUBLE_GAP = 12'd1000;

	// Gesture codes
	typedef enum logic [1:0] {
		GEST_PWR_ON  = 2'd0,
		GEST_SINGLE  = 2'd1,
		GEST_DOUBLE  = 2'd2,
		GEST_PWR_OFF = 2'd3
	} gesture_t;

	// Classifier phases
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_SETTLE = 3'd1,
		PH_DEB    = 3'd2,
		PH_HOLD   = 3'd3,
		PH_REL    = 3'd4,
		PH_GAP    = 3'd5,
		PH_WAITUP = 3'd6
	} phase_t;

	typedef struct packed {
		logic [REG_W-1:0] settle;
		logic [REG_W-1:0] debounce;
		logic [REG_W-1:0] long_press;
		logic [REG_W-1:0] release_thr;
		logic [REG_W-1:0] double_gap;
	} cfg_t;

	typedef struct packed {
		logic     valid;
		gesture_t gesture;
		logic     powered;
	} result_t;

endpackage

// ===== hw/rtl/bgc_cfg.sv =====
module bgc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [bgc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bgc_pkg::REG_W-1:0]        cfg_data,
	output bgc_pkg::cfg_t                    cfg
);
	import bgc_pkg::*;

	cfg_t cfg_q;

	// Threshold registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle      <= RST_SETTLE;
			cfg_q.debounce    <= RST_DEBOUNCE;
			cfg_q.long_press  <= RST_LONG_PRESS;
			cfg_q.release_thr <= RST_RELEASE;
			cfg_q.double_gap  <= RST_DOUBLE_GAP;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SETTLE:     cfg_q.settle      <= cfg_data;
				CFG_DEBOUNCE:   cfg_q.debounce    <= cfg_data;
				CFG_LONG_PRESS: cfg_q.long_press  <= cfg_data;
				CFG_RELEASE:    cfg_q.release_thr <= cfg_data;
				CFG_DOUBLE_GAP: cfg_q.double_gap  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/bgc_fsm.sv =====
module bgc_fsm #(
	parameter int unsigned COUNT_WIDTH = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bgc_pkg::cfg_t     cfg,
	input  logic              step,
	input  logic              pressed,
	output bgc_pkg::result_t  res
);
	import bgc_pkg::*;

	localparam int unsigned CMP_W = (COUNT_WIDTH + 1 > REG_W) ? COUNT_WIDTH + 1 : REG_W;

	phase_t                 phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic                   power_q, power_d;
	logic                   second_q, second_d;

	logic [COUNT_WIDTH:0]   cnt_inc;
	logic [CMP_W-1:0]       cnt_ext;
	logic [COUNT_WIDTH-1:0] cnt_sat;
	logic                   ge_settle, gt_deb, gt_long, gt_rel, gt_gap;

	// Count including this tick, one bit wider, then saturated for storage
	assign cnt_inc = {1'b0, count_q} + {{COUNT_WIDTH{1'b0}}, 1'b1};
	assign cnt_ext = CMP_W'(cnt_inc);
	assign cnt_sat = cnt_inc[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : cnt_inc[COUNT_WIDTH-1:0];

	// Threshold compares
	assign ge_settle = cnt_ext >= CMP_W'(cfg.settle);
	assign gt_deb    = cnt_ext >  CMP_W'(cfg.debounce);
	assign gt_long   = cnt_ext >  CMP_W'(cfg.long_press);
	assign gt_rel    = cnt_ext >  CMP_W'(cfg.release_thr);
	assign gt_gap    = cnt_ext >  CMP_W'(cfg.double_gap);

	// Next state
	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		power_d  = power_q;
		second_d = second_q;
		unique case (phase_q)
			PH_SETTLE: begin
				if (ge_settle) begin
					phase_d = PH_DEB;
					count_d = '0;
				end else begin
					count_d = cnt_sat;
				end
			end
			PH_DEB: begin
				if (!pressed) begin
					count_d = '0;
				end else if (gt_deb) begin
					phase_d = PH_HOLD;
					count_d = '0;
				end else begin
					count_d = cnt_sat;
				end
			end
			PH_HOLD: begin
				if (!pressed) begin
					phase_d = PH_REL;
					count_d = '0;
				end else if (gt_long) begin
					power_d  = ~power_q;
					phase_d  = PH_WAITUP;
					second_d = 1'b0;
					count_d  = '0;
				end else begin
					count_d = cnt_sat;
				end
			end
			PH_REL: begin
				if (pressed) begin
					count_d = '0;
				end else if (gt_rel) begin
					phase_d = PH_GAP;
					count_d = '0;
				end else begin
					count_d = cnt_sat;
				end
			end
			PH_GAP: begin
				if (pressed) begin
					second_d = 1'b1;
					phase_d  = PH_WAITUP;
					count_d  = '0;
				end else if (gt_gap) begin
					phase_d = PH_IDLE;
					count_d = '0;
				end else begin
					count_d = cnt_sat;
				end
			end
			PH_WAITUP: begin
				if (!pressed) begin
					phase_d  = PH_IDLE;
					count_d  = '0;
					second_d = 1'b0;
				end
			end
			default: begin
				// idle and the unused code
				count_d  = '0;
				second_d = 1'b0;
				if (!pressed) begin
					phase_d = PH_IDLE;
				end else if (cfg.settle == '0) begin
					phase_d = PH_DEB;
				end else begin
					phase_d = PH_SETTLE;
				end
			end
		endcase
	end

	// Result for this sample
	always_comb begin
		res.valid   = 1'b0;
		res.gesture = GEST_SINGLE;
		res.powered = power_q;
		unique case (phase_q)
			PH_HOLD: begin
				if (pressed && gt_long) begin
					res.valid   = step;
					res.gesture = power_q ? GEST_PWR_OFF : GEST_PWR_ON;
					res.powered = ~power_q;
				end
			end
			PH_GAP: begin
				if (!pressed && gt_gap) begin
					res.valid = step;
				end
			end
			PH_WAITUP: begin
				if (!pressed && second_q) begin
					res.valid   = step;
					res.gesture = GEST_DOUBLE;
				end
			end
			default: ;
		endcase
	end

	// State registers advance once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			count_q  <= '0;
			power_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			power_q  <= power_d;
			second_q <= second_d;
		end
	end

endmodule

// ===== hw/rtl/bgc_out.sv =====
module bgc_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  bgc_pkg::result_t  res,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        gesture,
	output logic              powered
);
	import bgc_pkg::*;

	logic       valid_q;
	gesture_t   gesture_q;
	logic       power_q;

	// Slot is free when empty or being drained this cycle
	assign space = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload, no reset needed
	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			gesture_q <= res.gesture;
			power_q   <= res.powered;
		end
	end

	assign out_valid = valid_q;
	assign gesture   = gesture_q;
	assign powered   = power_q;

endmodule

// ===== hw/rtl/button_gesture_classifier.sv =====
// Channel   Handshake             Payload
// input     in_valid / in_ready   pressed
// output    out_valid / out_ready gesture, powered
// config    cfg_wr_en             cfg_index, cfg_data
//
// One request per cycle unless the output is stalled and the input register is full.
// Samples land in an input register, the phase machine classifies them into the
// result register. Reset clears the phase, counter and power state and reloads
// the default thresholds.
// A stalled output holds the result and the input stage stops once it is full.
module button_gesture_classifier #(
	parameter int unsigned COUNT_WIDTH = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [bgc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bgc_pkg::REG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           pressed,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     gesture,
	output logic                           powered
);
	import bgc_pkg::*;

	cfg_t    cfg;
	result_t res;
	logic    valid_s1;
	logic    pressed_s1;
	logic    space;
	logic    step;

	bgc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Sample moves on when the result slot can take it
	assign step     = valid_s1 && space;
	assign in_ready = !valid_s1 || space;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pressed_s1 <= pressed;
		end
	end

	bgc_fsm #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (step),
		.pressed (pressed_s1),
		.res     (res)
	);

	bgc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.res       (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.gesture   (gesture),
		.powered   (powered)
	);

endmodule

// ===== verif/tb.sv =====
module tb;
	import bgc_pkg::*;

	localparam int unsigned CLK_PERIOD = 20;
	localparam int unsigned COUNT_W    = 12;
	// a result passes the input and result registers; leave margin before reconfiguring
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned CHUNK_SAMPLES = 65;

	typedef struct packed {
		gesture_t g;
		logic     pw;
	} gesture_event_t;

	// one row of the directed script: a level repeated, optionally with a hand-typed outcome
	typedef struct packed {
		logic        level;
		logic [15:0] reps;
		logic        typed;
		logic        fires;
		gesture_t    g;
		logic        pw;
	} script_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 pressed;
	logic                 out_valid;
	logic                 out_ready;
	logic [1:0]           gesture;
	logic                 powered;

	// classifier model state
	phase_t               cls_phase;
	logic [COUNT_W-1:0]   tick_cnt;
	logic                 pwr_state;
	logic                 second_seen;
	cfg_t                 thr;

	gesture_event_t       pending_gestures[$];
	int unsigned          errors = 0;
	int unsigned          samples_sent = 0;
	int unsigned          src_idle_pct = 0;
	int unsigned          snk_idle_pct = 0;
	bit                   hold_off_req = 1'b0;

	// thresholds for the script: zero settle/debounce/release, long 2, gap 1
	script_row_t dir_script [18] = '{
		'{1'b0, 16'd2, 1'b1, 1'b0, GEST_SINGLE,  1'b0},
		'{1'b1, 16'd4, 1'b0, 1'b0, GEST_SINGLE,  1'b0},
		'{1'b1, 16'd1, 1'b1, 1'b1, GEST_PWR_ON,  1'b1},
		'{1'b0, 16'd1, 1'b0, 1'b0, GEST_SINGLE,  1'b0},
		'{1'b1, 16'd4, 1'b0, 1'b0, GEST_SINGLE,  1'b0},
		'{1'b1, 16'd1, 1'b1, 1'b1, GEST_PWR_OFF, 1'b0},
		'{1'b0, 16'd1, 1'b0, 1'b0, GEST_SINGLE,  1'b0},
		'{1'b1, 16'd2, 1'b0, 1'b0, GEST_SINGLE,  1'b0},
		'{1'b0, 16'd3, 1'b0, 1'b0, GEST_SINGLE,  1'b0},
		'{1'b0, 16'd1, 1'b1, 1'b1, GEST_SINGLE,  1'b0},
		'{1'b1, 16'd2, 1'b0, 1'b0, GEST_SINGLE,  1'b0},
		'{1'b0, 16'd2, 1'b0, 1'b0, GEST_SINGLE,  1'b0},
		'{1'b1, 16'd2, 1'b0, 1'b0, GEST_SINGLE,  1'b0},
		'{1'b0, 16'd1, 1'b1, 1'b1, GEST_DOUBLE,  1'b0},
		// bounce during the release debounce
		'{1'b1, 16'd2, 1'b0, 1'b0, GEST_SINGLE,  1'b0},
		'{1'b0, 16'd1, 1'b0, 1'b0, GEST_SINGLE,  1'b0},
		'{1'b1, 16'd1, 1'b0, 1'b0, GEST_SINGLE,  1'b0},
		'{1'b0, 16'd3, 1'b0, 1'b0, GEST_SINGLE,  1'b0}
	};

	button_gesture_classifier u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pressed   (pressed),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.gesture   (gesture),
		.powered   (powered)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// counter update that sticks at all ones
	function automatic logic [COUNT_W-1:0] saturate(input logic [COUNT_W:0] n);
		return n[COUNT_W] ? {COUNT_W{1'b1}} : n[COUNT_W-1:0];
	endfunction

	// small thresholds most of the time so gestures stay short
	function automatic logic [REG_W-1:0] rand_thr();
		return ($urandom_range(9) == 0) ? REG_W'($urandom_range(7, 30))
			: REG_W'($urandom_range(0, 6));
	endfunction

	// advance the classifier by one sample, report a gesture if one completes
	task automatic classify_sample(input logic down, output bit fired,
			output gesture_event_t ev);
		logic [COUNT_W:0] n;
		n = tick_cnt + 1'b1;
		fired = 1'b0;
		ev.g = GEST_SINGLE;
		ev.pw = pwr_state;
		case (cls_phase)
		PH_SETTLE: begin
			if (n >= thr.settle) begin
				cls_phase = PH_DEB;
				tick_cnt = '0;
			end else
				tick_cnt = saturate(n);
		end
		PH_DEB: begin
			if (!down)
				tick_cnt = '0;
			else if (n > thr.debounce) begin
				cls_phase = PH_HOLD;
				tick_cnt = '0;
			end else
				tick_cnt = saturate(n);
		end
		PH_HOLD: begin
			if (!down) begin
				// the releasing sample is not counted
				cls_phase = PH_REL;
				tick_cnt = '0;
			end else if (n > thr.long_press) begin
				pwr_state = ~pwr_state;
				cls_phase = PH_WAITUP;
				second_seen = 1'b0;
				tick_cnt = '0;
				fired = 1'b1;
				ev.g = pwr_state ? GEST_PWR_ON : GEST_PWR_OFF;
				ev.pw = pwr_state;
			end else
				tick_cnt = saturate(n);
		end
		PH_REL: begin
			if (down)
				tick_cnt = '0;
			else if (n > thr.release_thr) begin
				cls_phase = PH_GAP;
				tick_cnt = '0;
			end else
				tick_cnt = saturate(n);
		end
		PH_GAP: begin
			if (down) begin
				second_seen = 1'b1;
				cls_phase = PH_WAITUP;
				tick_cnt = '0;
			end else if (n > thr.double_gap) begin
				cls_phase = PH_IDLE;
				tick_cnt = '0;
				fired = 1'b1;
				ev.g = GEST_SINGLE;
			end else
				tick_cnt = saturate(n);
		end
		PH_WAITUP: begin
			if (!down) begin
				cls_phase = PH_IDLE;
				tick_cnt = '0;
				if (second_seen) begin
					second_seen = 1'b0;
					fired = 1'b1;
					ev.g = GEST_DOUBLE;
				end
			end
		end
		default: begin
			tick_cnt = '0;
			second_seen = 1'b0;
			if (!down)
				cls_phase = PH_IDLE;
			else if (thr.settle == '0)
				cls_phase = PH_DEB;
			else
				cls_phase = PH_SETTLE;
		end
		endcase
	endtask

	// offer one sample request, with random idle cycles ahead of it
	task automatic send_sample(input logic level, output bit fired, output gesture_event_t ev);
		if ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		in_valid <= 1'b1;
		pressed <= level;
		do @(posedge clk); while (!in_ready);
		samples_sent++;
		classify_sample(level, fired, ev);
	endtask

	task automatic drive_level(input logic level, input int unsigned reps);
		bit             fired;
		gesture_event_t ev;
		repeat (reps) begin
			send_sample(level, fired, ev);
			if (fired)
				pending_gestures.push_back(ev);
		end
	endtask

	// stop sending, let every expected gesture come back and the pipe empty
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_gestures.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all five thresholds plus one write to an unused index
	task automatic load_thresholds(input cfg_t c, input logic [CFG_IDX_W-1:0] spare_idx);
		for (int i = 0; i < 6; i++) begin
			cfg_wr_en <= 1'b1;
			case (i)
			0: begin
				cfg_index <= CFG_SETTLE;
				cfg_data <= c.settle;
			end
			1: begin
				cfg_index <= CFG_DEBOUNCE;
				cfg_data <= c.debounce;
			end
			2: begin
				cfg_index <= CFG_LONG_PRESS;
				cfg_data <= c.long_press;
			end
			3: begin
				cfg_index <= CFG_RELEASE;
				cfg_data <= c.release_thr;
			end
			4: begin
				cfg_index <= CFG_DOUBLE_GAP;
				cfg_data <= c.double_gap;
			end
			default: begin
				cfg_index <= spare_idx;
				cfg_data <= REG_W'($urandom);
			end
			endcase
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		thr = c;
	endtask

	// one gesture shaped around the current thresholds, or some noise
	task automatic play_gesture();
		int unsigned kind;
		int unsigned lead;
		kind = $urandom_range(99);
		// samples from the first press until the hold is being timed
		lead = 2 + thr.settle + thr.debounce;
		if (kind < 20) begin
			// long press, then let go
			drive_level(1'b1, lead + thr.long_press + 1 + $urandom_range(0, 3));
			drive_level(1'b0, 1 + $urandom_range(0, 2));
		end else if (kind < 45) begin
			// short press, window runs out
			drive_level(1'b1, lead + $urandom_range(0, thr.long_press));
			drive_level(1'b0, 3 + thr.release_thr + thr.double_gap + $urandom_range(0, 2));
		end else if (kind < 70) begin
			// short press, second press inside the window
			drive_level(1'b1, lead + $urandom_range(0, thr.long_press));
			drive_level(1'b0, 2 + thr.release_thr + $urandom_range(0, thr.double_gap));
			drive_level(1'b1, 1 + $urandom_range(0, 3));
			drive_level(1'b0, 1 + $urandom_range(0, 2));
		end else if (kind < 85) begin
			repeat ($urandom_range(1, 8))
				drive_level(1'($urandom_range(1)), 1);
		end else begin
			// bouncy press, then a long quiet stretch
			drive_level(1'b1, $urandom_range(1, lead));
			drive_level(1'b0, $urandom_range(1, 4));
			drive_level(1'b1, $urandom_range(1, lead));
			drive_level(1'b0, 3 + thr.release_thr + thr.double_gap);
		end
	endtask

	// gesture sink: check accepted results, random back-pressure, one long hold-off
	initial begin
		int unsigned    held;
		gesture_event_t exp_ev;
		held = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_gestures.size() == 0) begin
					$error("unexpected gesture %0d powered %0d", gesture, powered);
					errors++;
				end else begin
					exp_ev = pending_gestures.pop_front();
					if (gesture !== exp_ev.g) begin
						$error("gesture: expected %0d, got %0d", exp_ev.g, gesture);
						errors++;
					end
					if (powered !== exp_ev.pw) begin
						$error("powered: expected %0d, got %0d", exp_ev.pw, powered);
						errors++;
					end
				end
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				held = HOLD_OFF_CYCLES;
			end
			if (held != 0) begin
				held--;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// run limit
	initial begin
		#(CLK_PERIOD * 1_000_000);
		$display("button_gesture_classifier test failed");
		$finish;
	end

	// main sequence
	initial begin
		cfg_t           c;
		bit             fired;
		gesture_event_t ev;
		int unsigned    chunk;
		int unsigned    chunk_start;

		arst_n = 1'b0;
		in_valid <= 1'b0;
		pressed <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cls_phase = PH_IDLE;
		tick_cnt = '0;
		pwr_state = 1'b0;
		second_seen = 1'b0;
		thr = '{RST_SETTLE, RST_DEBOUNCE, RST_LONG_PRESS, RST_RELEASE, RST_DOUBLE_GAP};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 25;
		snk_idle_pct = 73;

		// double press under the reset thresholds
		drive_level(1'b1, 25);
		drive_level(1'b0, 40);
		drive_level(1'b1, 3);
		drive_level(1'b0, 2);

		// directed script
		wait_idle();
		c = '{12'd0, 12'd0, 12'd2, 12'd0, 12'd1};
		load_thresholds(c, CFG_IDX_W'(5));
		foreach (dir_script[r]) begin
			for (int k = 0; k < dir_script[r].reps; k++) begin
				send_sample(dir_script[r].level, fired, ev);
				if (dir_script[r].typed) begin
					if (dir_script[r].fires)
						pending_gestures.push_back('{dir_script[r].g, dir_script[r].pw});
				end else if (fired)
					pending_gestures.push_back(ev);
			end
		end

		// random gestures in chunks, new thresholds each chunk
		chunk = 0;
		while (chunk < 6) begin
			wait_idle();
			if (chunk == 2) begin
				src_idle_pct = 73;
				snk_idle_pct = 25;
			end else if (chunk == 4) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			if (chunk == 1)
				c = '0;
			else
				c = '{rand_thr(), rand_thr(), rand_thr(), rand_thr(), rand_thr()};
			load_thresholds(c, CFG_IDX_W'(5 + chunk % 3));
			// stall the sink long enough to back up the input
			if (chunk == 2)
				hold_off_req = 1'b1;
			chunk_start = samples_sent;
			while (samples_sent - chunk_start < CHUNK_SAMPLES)
				play_gesture();
			chunk++;
		end

		// all thresholds at the top: a press only sits in the settle delay
		wait_idle();
		c = '1;
		load_thresholds(c, CFG_IDX_W'(7));
		drive_level(1'b1, 30);
		drive_level(1'b0, 5);

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("button_gesture_classifier test passed");
		else
			$display("button_gesture_classifier test failed");
		$finish;
	end

endmodule
